@@ hw/rtl/diir_pkg.sv @@
// Package for the dual IIR defect channel filter: widths, row layout, sequencer states,
// fixed-point coefficient tables and the output scaling helpers.
// Depends on nothing; used by dual_iir_defect_channel_filter_unit.
package diir_pkg;

    localparam int CHANNELS       = 12;
    localparam int CH_W           = 4;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 40;
    localparam int OUT_FRAC       = 32;
    localparam int HIST_W         = SAMPLE_BITS + OUT_FRAC;
    localparam int HP_ORDER       = 4;
    localparam int LP_ORDER       = 5;
    localparam int COEF_W         = 45;
    localparam int DAT_W          = 25;
    localparam int PROD_W         = COEF_W + DAT_W;
    localparam int ACC_W          = 106;
    localparam int CHUNK_W        = 19;
    localparam int TOP_W          = HIST_W - 2 * CHUNK_W;
    localparam int HP_STEPS       = 1 + HP_ORDER * 4;
    localparam int LP_STEPS       = 1 + LP_ORDER * 4;
    localparam int STEP_W         = 5;

    localparam longint unsigned DEC_SCALE = 64'd100000000000000;

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef logic signed [HIST_W-1:0]      hist_t;
    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [DAT_W-1:0]       dat_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [STEP_W-1:0]             step_t;

    typedef struct packed {
        smp_t  [HP_ORDER-1:0] hp_x;
        hist_t [HP_ORDER-1:0] hp_y;
        smp_t  [LP_ORDER-1:0] lp_x;
        hist_t [LP_ORDER-1:0] lp_y;
        smp_t                 prev;
    } chan_row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_HP_MAC,
        ST_HP_DRAIN,
        ST_HP_FIN,
        ST_LP_MAC,
        ST_LP_DRAIN,
        ST_LP_FIN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SH_IN,
        SH_C0,
        SH_C1,
        SH_C2
    } term_sh_t;

    function automatic longint to_fixed(input longint d);
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        m = (d < 0) ? longint'(-d) : longint'(d);
        q = m / DEC_SCALE;
        r = m % DEC_SCALE;
        for (int i = 0; i < COEF_FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= DEC_SCALE) begin
                r = r - DEC_SCALE;
                q = q | 64'd1;
            end
        end
        r = r << 1;
        if (r >= DEC_SCALE) begin
            q = q + 64'd1;
        end
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    localparam coef_t HP_B [HP_ORDER+1] = '{
        coef_t'(to_fixed(64'sd99829117464281)),
        coef_t'(to_fixed(-64'sd399316469857123)),
        coef_t'(to_fixed(64'sd598974704785684)),
        coef_t'(to_fixed(-64'sd399316469857123)),
        coef_t'(to_fixed(64'sd99829117464281))
    };

    // feedback terms stored negated
    localparam coef_t HP_NA [HP_ORDER] = '{
        coef_t'(to_fixed(64'sd399657942627525)),
        coef_t'(to_fixed(-64'sd598974412777420)),
        coef_t'(to_fixed(64'sd398974997086573)),
        coef_t'(to_fixed(-64'sd99658526936971))
    };

    localparam coef_t LP_B [LP_ORDER+1] = '{
        coef_t'(to_fixed(64'sd97904252295968)),
        coef_t'(to_fixed(64'sd489521261479841)),
        coef_t'(to_fixed(64'sd979042522959681)),
        coef_t'(to_fixed(64'sd979042522959681)),
        coef_t'(to_fixed(64'sd489521261479841)),
        coef_t'(to_fixed(64'sd97904252295968))
    };

    localparam coef_t LP_NA [LP_ORDER] = '{
        coef_t'(to_fixed(-64'sd495764005747337)),
        coef_t'(to_fixed(-64'sd983145602608809)),
        coef_t'(to_fixed(-64'sd974851604793013)),
        coef_t'(to_fixed(-64'sd483322434145496)),
        coef_t'(to_fixed(-64'sd95852426176326))
    };

    function automatic hist_t sat_hist(input acc_t acc);
        logic [ACC_W-HIST_W-COEF_FRAC_BITS:0] top;
        hist_t                                res;
        top = acc[ACC_W-1:HIST_W+COEF_FRAC_BITS-1];
        if (top == '0 || top == '1) begin
            res = acc[HIST_W+COEF_FRAC_BITS-1:COEF_FRAC_BITS];
        end else if (acc[ACC_W-1]) begin
            res = {1'b1, {(HIST_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(HIST_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic smp_t trunc_int(input hist_t y);
        smp_t res;
        res = y[HIST_W-1:OUT_FRAC];
        if (y[HIST_W-1] && y[OUT_FRAC-1:0] != '0) begin
            res = res + smp_t'(1);
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/dual_iir_defect_channel_filter_unit.sv @@
// Top level of the dual IIR defect channel filter: per-channel state memory, sequencer
// and one shared 45 x 25 bit multiplier with a 106-bit accumulator.
// Depends on diir_pkg.
//
// Each transaction carries one sample for one of 12 channels and returns one result
// (channel, high-pass filtered value, defect value); a channel index of 12 or more is
// dropped without a result. The block takes one transaction at a time: from acceptance
// a sample passes the load state, 17 multiply steps, a drain and a finish state for the
// 4th-order high-pass, 21 multiply steps, a drain and a finish state for the 5th-order
// low-pass, the write-back state and the done state before its result is placed in the
// output register, and no new sample is taken until then. The single shared multiplier
// handles one coefficient against one input sample or one slice (19, 19 or 18 bits) of
// an output history per cycle. The output register lets
// the next sample be taken while a result still waits; the block holds in its last
// step if the previous result has not been taken. No clearing pass is needed after
// reset: a per-channel valid flag makes unwritten channels read as zero.
module dual_iir_defect_channel_filter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [diir_pkg::CH_W-1:0]           s_channel,
    input  logic signed [diir_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [diir_pkg::CH_W-1:0]           m_channel_out,
    output logic signed [diir_pkg::SAMPLE_BITS-1:0] m_filtered,
    output logic signed [diir_pkg::SAMPLE_BITS-1:0] m_defect
);

    diir_pkg::state_t    state_reg, state_next;
    diir_pkg::step_t     step_reg, step_next;
    diir_pkg::acc_t      acc_reg, acc_next;
    diir_pkg::prod_t     prod_reg, prod_next;
    diir_pkg::term_sh_t  sh_reg, sh_next;
    logic                pvalid_reg, pvalid_next;
    diir_pkg::chan_row_t row_reg, row_next;
    diir_pkg::chan_row_t rd_row_reg;
    diir_pkg::chan_row_t row_mem [diir_pkg::CHANNELS];
    logic [diir_pkg::CHANNELS-1:0] valid_reg, valid_next;
    logic [diir_pkg::CH_W-1:0]     ch_reg, ch_next;
    diir_pkg::smp_t      x_reg, x_next;
    diir_pkg::smp_t      filt_reg, filt_next;
    diir_pkg::smp_t      defect_reg, defect_next;
    logic                m_valid_reg, m_valid_next;
    logic [diir_pkg::CH_W-1:0] m_ch_reg, m_ch_next;
    diir_pkg::smp_t      m_filt_reg, m_filt_next;
    diir_pkg::smp_t      m_def_reg, m_def_next;

    logic                in_accept;
    logic                mac_lp;
    diir_pkg::step_t     t;
    diir_pkg::coef_t     coef;
    diir_pkg::dat_t      dat;
    diir_pkg::hist_t     yh;
    diir_pkg::smp_t      xh;
    diir_pkg::acc_t      pe;
    diir_pkg::acc_t      addend;
    diir_pkg::hist_t     y_new;
    diir_pkg::smp_t      y_int;
    logic signed [diir_pkg::SAMPLE_BITS:0] diff;
    logic                out_free;

    assign s_ready       = (state_reg == diir_pkg::ST_IDLE);
    assign in_accept     = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_ch_reg;
    assign m_filtered    = m_filt_reg;
    assign m_defect      = m_def_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            diir_pkg::ST_IDLE: begin
                if (s_valid && s_channel < diir_pkg::CH_W'(diir_pkg::CHANNELS)) begin
                    state_next = diir_pkg::ST_LOAD;
                end
            end
            diir_pkg::ST_LOAD:     state_next = diir_pkg::ST_HP_MAC;
            diir_pkg::ST_HP_MAC: begin
                if (step_reg == diir_pkg::STEP_W'(diir_pkg::HP_STEPS - 1)) begin
                    state_next = diir_pkg::ST_HP_DRAIN;
                end
            end
            diir_pkg::ST_HP_DRAIN: state_next = diir_pkg::ST_HP_FIN;
            diir_pkg::ST_HP_FIN:   state_next = diir_pkg::ST_LP_MAC;
            diir_pkg::ST_LP_MAC: begin
                if (step_reg == diir_pkg::STEP_W'(diir_pkg::LP_STEPS - 1)) begin
                    state_next = diir_pkg::ST_LP_DRAIN;
                end
            end
            diir_pkg::ST_LP_DRAIN: state_next = diir_pkg::ST_LP_FIN;
            diir_pkg::ST_LP_FIN:   state_next = diir_pkg::ST_WRITE;
            diir_pkg::ST_WRITE:    state_next = diir_pkg::ST_DONE;
            diir_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = diir_pkg::ST_IDLE;
                end
            end
            default:               state_next = diir_pkg::ST_IDLE;
        endcase
    end

    // operand selection for the shared multiplier
    always_comb begin
        mac_lp = (state_reg == diir_pkg::ST_LP_MAC);
        t      = step_reg - diir_pkg::STEP_W'(1);
        xh     = mac_lp ? row_reg.lp_x[t[4:2]] : row_reg.hp_x[t[3:2]];
        yh     = mac_lp ? row_reg.lp_y[t[4:2]] : row_reg.hp_y[t[3:2]];
        coef   = '0;
        dat    = '0;
        sh_next = diir_pkg::SH_IN;
        if (step_reg == '0) begin
            coef    = mac_lp ? diir_pkg::LP_B[0] : diir_pkg::HP_B[0];
            dat     = diir_pkg::DAT_W'(mac_lp ? filt_reg : x_reg);
            sh_next = diir_pkg::SH_IN;
        end else begin
            case (t[1:0])
                2'd0: begin
                    coef    = mac_lp ? diir_pkg::LP_B[3'(t[4:2] + 3'd1)]
                                     : diir_pkg::HP_B[3'(t[4:2] + 3'd1)];
                    dat     = diir_pkg::DAT_W'(xh);
                    sh_next = diir_pkg::SH_IN;
                end
                2'd1: begin
                    coef    = mac_lp ? diir_pkg::LP_NA[t[4:2]] : diir_pkg::HP_NA[t[3:2]];
                    dat     = $signed({{(diir_pkg::DAT_W - diir_pkg::CHUNK_W){1'b0}},
                                       yh[diir_pkg::CHUNK_W-1:0]});
                    sh_next = diir_pkg::SH_C0;
                end
                2'd2: begin
                    coef    = mac_lp ? diir_pkg::LP_NA[t[4:2]] : diir_pkg::HP_NA[t[3:2]];
                    dat     = $signed({{(diir_pkg::DAT_W - diir_pkg::CHUNK_W){1'b0}},
                                       yh[2*diir_pkg::CHUNK_W-1:diir_pkg::CHUNK_W]});
                    sh_next = diir_pkg::SH_C1;
                end
                default: begin
                    coef    = mac_lp ? diir_pkg::LP_NA[t[4:2]] : diir_pkg::HP_NA[t[3:2]];
                    dat     = $signed({{(diir_pkg::DAT_W - diir_pkg::TOP_W)
                                        {yh[diir_pkg::HIST_W-1]}},
                                       yh[diir_pkg::HIST_W-1:2*diir_pkg::CHUNK_W]});
                    sh_next = diir_pkg::SH_C2;
                end
            endcase
        end
        prod_next = diir_pkg::prod_t'(coef) * diir_pkg::prod_t'(dat);
    end

    always_comb begin
        pe = diir_pkg::ACC_W'(prod_reg);
        case (sh_reg)
            diir_pkg::SH_IN: addend = pe <<< diir_pkg::OUT_FRAC;
            diir_pkg::SH_C0: addend = pe;
            diir_pkg::SH_C1: addend = pe <<< diir_pkg::CHUNK_W;
            diir_pkg::SH_C2: addend = pe <<< (2 * diir_pkg::CHUNK_W);
            default:         addend = pe;
        endcase
        y_new = diir_pkg::sat_hist(acc_reg);
        y_int = diir_pkg::trunc_int(y_new);
        diff  = {row_reg.prev[diir_pkg::SAMPLE_BITS-1], row_reg.prev}
              - {y_int[diir_pkg::SAMPLE_BITS-1], y_int};
    end

    always_comb begin
        step_next    = step_reg;
        acc_next     = acc_reg;
        pvalid_next  = (state_reg == diir_pkg::ST_HP_MAC) || (state_reg == diir_pkg::ST_LP_MAC);
        row_next     = row_reg;
        valid_next   = valid_reg;
        ch_next      = ch_reg;
        x_next       = x_reg;
        filt_next    = filt_reg;
        defect_next  = defect_reg;
        m_valid_next = m_valid_reg;
        m_ch_next    = m_ch_reg;
        m_filt_next  = m_filt_reg;
        m_def_next   = m_def_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pvalid_reg) begin
            acc_next = acc_reg + addend;
        end

        case (state_reg)
            diir_pkg::ST_IDLE: begin
                if (in_accept) begin
                    ch_next = s_channel;
                    x_next  = s_sample;
                end
            end
            diir_pkg::ST_LOAD: begin
                row_next  = valid_reg[ch_reg] ? rd_row_reg : '0;
                step_next = '0;
                acc_next  = '0;
            end
            diir_pkg::ST_HP_MAC, diir_pkg::ST_LP_MAC: begin
                step_next = step_reg + diir_pkg::STEP_W'(1);
            end
            diir_pkg::ST_HP_FIN: begin
                row_next.hp_x[diir_pkg::HP_ORDER-1:1] = row_reg.hp_x[diir_pkg::HP_ORDER-2:0];
                row_next.hp_y[diir_pkg::HP_ORDER-1:1] = row_reg.hp_y[diir_pkg::HP_ORDER-2:0];
                row_next.hp_x[0] = x_reg;
                row_next.hp_y[0] = y_new;
                filt_next = y_int;
                step_next = '0;
                acc_next  = '0;
            end
            diir_pkg::ST_LP_FIN: begin
                row_next.lp_x[diir_pkg::LP_ORDER-1:1] = row_reg.lp_x[diir_pkg::LP_ORDER-2:0];
                row_next.lp_y[diir_pkg::LP_ORDER-1:1] = row_reg.lp_y[diir_pkg::LP_ORDER-2:0];
                row_next.lp_x[0] = filt_reg;
                row_next.lp_y[0] = y_new;
                row_next.prev    = filt_reg;
                if (diff[diir_pkg::SAMPLE_BITS] != diff[diir_pkg::SAMPLE_BITS-1]) begin
                    defect_next = diff[diir_pkg::SAMPLE_BITS]
                                ? {1'b1, {(diir_pkg::SAMPLE_BITS-1){1'b0}}}
                                : {1'b0, {(diir_pkg::SAMPLE_BITS-1){1'b1}}};
                end else begin
                    defect_next = diff[diir_pkg::SAMPLE_BITS-1:0];
                end
            end
            diir_pkg::ST_WRITE: begin
                valid_next[ch_reg] = 1'b1;
            end
            diir_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ch_next    = ch_reg;
                    m_filt_next  = filt_reg;
                    m_def_next   = defect_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= diir_pkg::ST_IDLE;
            pvalid_reg  <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pvalid_reg  <= pvalid_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        sh_reg     <= sh_next;
        row_reg    <= row_next;
        ch_reg     <= ch_next;
        x_reg      <= x_next;
        filt_reg   <= filt_next;
        defect_reg <= defect_next;
        m_ch_reg   <= m_ch_next;
        m_filt_reg <= m_filt_next;
        m_def_reg  <= m_def_next;
    end

    always_ff @(posedge aclk) begin
        if (in_accept && s_channel < diir_pkg::CH_W'(diir_pkg::CHANNELS)) begin
            rd_row_reg <= row_mem[s_channel];
        end
        if (state_reg == diir_pkg::ST_WRITE) begin
            row_mem[ch_reg] <= row_reg;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_channel < diir_pkg::CH_W'(diir_pkg::CHANNELS)) |=> !s_ready)
        else $error("block ready again straight after taking an in-range transaction");

    a_product_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        pvalid_reg |-> (state_reg == diir_pkg::ST_HP_MAC || state_reg == diir_pkg::ST_HP_DRAIN
                        || state_reg == diir_pkg::ST_LP_MAC
                        || state_reg == diir_pkg::ST_LP_DRAIN))
        else $error("product accumulated outside a filter pass");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == diir_pkg::ST_WRITE) |-> (ch_reg < diir_pkg::CH_W'(diir_pkg::CHANNELS)))
        else $error("write-back to a channel beyond the state memory");

    a_result_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == diir_pkg::ST_DONE && m_valid_reg && !m_ready)
            |=> (state_reg == diir_pkg::ST_DONE))
        else $error("result left before the output register was free");

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for dual_iir_defect_channel_filter_unit: a directed table, then about
// a thousand random transactions, checked against a bit-exact high-pass/low-pass predictor.
// Depends on diir_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int  RANDOM_ITEMS = 1030;
    localparam int  STALL_CYCLES = 400;
    localparam int  TAIL_CYCLES  = 60;
    localparam longint TEN14     = 64'sd100000000000000;
    localparam logic signed [127:0] HIST_HI =
        (128'sd1 <<< (diir_pkg::HIST_W - 1)) - 128'sd1;
    localparam logic signed [127:0] HIST_LO = -HIST_HI - 128'sd1;
    localparam longint SMP_HI = (64'sd1 <<< (diir_pkg::SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SMP_LO = -SMP_HI - 64'sd1;

    typedef struct packed {
        logic [diir_pkg::CH_W-1:0] ch;
        diir_pkg::smp_t            smp;
        logic                      typed;
        diir_pkg::smp_t            filt;
        diir_pkg::smp_t            dfct;
    } stim_row_t;

    typedef struct packed {
        logic [diir_pkg::CH_W-1:0] ch;
        diir_pkg::smp_t            filt;
        diir_pkg::smp_t            dfct;
    } chan_result_t;

    typedef struct {
        diir_pkg::smp_t  x[diir_pkg::LP_ORDER];
        diir_pkg::hist_t y[diir_pkg::LP_ORDER];
    } iir_hist_t;

    localparam int N_ROWS = 24;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{4'd0,  24'sd0,         1'b1, 24'sd0, 24'sd0},
        '{4'd11, 24'sd0,         1'b1, 24'sd0, 24'sd0},
        '{4'd12, 24'sd5,         1'b0, 24'sd0, 24'sd0},
        '{4'd15, -24'sd1,        1'b0, 24'sd0, 24'sd0},
        '{4'd0,  24'sd8388607,   1'b0, 24'sd0, 24'sd0},
        '{4'd0,  -24'sd8388608,  1'b0, 24'sd0, 24'sd0},
        '{4'd3,  24'sd8388607,   1'b0, 24'sd0, 24'sd0},
        '{4'd3,  -24'sd8388608,  1'b0, 24'sd0, 24'sd0},
        '{4'd3,  24'sd8388607,   1'b0, 24'sd0, 24'sd0},
        '{4'd3,  -24'sd8388608,  1'b0, 24'sd0, 24'sd0},
        '{4'd3,  24'sd8388607,   1'b0, 24'sd0, 24'sd0},
        '{4'd3,  -24'sd8388608,  1'b0, 24'sd0, 24'sd0},
        '{4'd3,  24'sd8388607,   1'b0, 24'sd0, 24'sd0},
        '{4'd5,  24'sd8388607,   1'b0, 24'sd0, 24'sd0},
        '{4'd5,  24'sd8388607,   1'b0, 24'sd0, 24'sd0},
        '{4'd5,  24'sd8388607,   1'b0, 24'sd0, 24'sd0},
        '{4'd5,  24'sd0,         1'b0, 24'sd0, 24'sd0},
        '{4'd7,  -24'sd1,        1'b0, 24'sd0, 24'sd0},
        '{4'd7,  24'sd1,         1'b0, 24'sd0, 24'sd0},
        '{4'd0,  24'sd0,         1'b0, 24'sd0, 24'sd0},
        '{4'd13, -24'sd8388608,  1'b0, 24'sd0, 24'sd0},
        '{4'd11, -24'sd8388608,  1'b0, 24'sd0, 24'sd0},
        '{4'd9,  24'sd12345,     1'b0, 24'sd0, 24'sd0},
        '{4'd2,  -24'sd4567890,  1'b0, 24'sd0, 24'sd0}
    };

    localparam longint HP_B_DEC [diir_pkg::HP_ORDER+1] = '{
        64'sd99829117464281, -64'sd399316469857123, 64'sd598974704785684,
        -64'sd399316469857123, 64'sd99829117464281};
    localparam longint HP_A_DEC [diir_pkg::HP_ORDER] = '{
        -64'sd399657942627525, 64'sd598974412777420,
        -64'sd398974997086573, 64'sd99658526936971};
    localparam longint LP_B_DEC [diir_pkg::LP_ORDER+1] = '{
        64'sd97904252295968, 64'sd489521261479841, 64'sd979042522959681,
        64'sd979042522959681, 64'sd489521261479841, 64'sd97904252295968};
    localparam longint LP_A_DEC [diir_pkg::LP_ORDER] = '{
        64'sd495764005747337, 64'sd983145602608809, 64'sd974851604793013,
        64'sd483322434145496, 64'sd95852426176326};

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [diir_pkg::CH_W-1:0] s_channel = '0;
    diir_pkg::smp_t            s_sample  = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic [diir_pkg::CH_W-1:0] m_channel_out;
    diir_pkg::smp_t            m_filtered;
    diir_pkg::smp_t            m_defect;

    longint         hp_b_q [diir_pkg::HP_ORDER+1];
    longint         hp_na_q [diir_pkg::HP_ORDER];
    longint         lp_b_q [diir_pkg::LP_ORDER+1];
    longint         lp_na_q [diir_pkg::LP_ORDER];
    iir_hist_t      hp_state [diir_pkg::CHANNELS];
    iir_hist_t      lp_state [diir_pkg::CHANNELS];
    diir_pkg::smp_t last_filtered [diir_pkg::CHANNELS];
    chan_result_t   results_due [$];
    int             mismatches = 0;
    int             send_idle  = 24;
    int             recv_idle  = 58;
    bit             stall_req  = 1'b0;
    bit             stall_done = 1'b0;

    dual_iir_defect_channel_filter_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_filtered    (m_filtered),
        .m_defect      (m_defect)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // nearest rounding, ties away from zero
    function automatic longint quantise_coef(input longint dec);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (dec < 0) ? 128'(-dec) : 128'(dec);
        q = ((mag << (diir_pkg::COEF_FRAC_BITS + 1)) + 128'(TEN14)) / (128'(TEN14) * 2);
        return (dec < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic diir_pkg::smp_t to_integer(input diir_pkg::hist_t y);
        longint v;
        v = y;
        if (v >= 0) begin
            return diir_pkg::smp_t'(v >>> diir_pkg::OUT_FRAC);
        end
        return diir_pkg::smp_t'(-((-v) >>> diir_pkg::OUT_FRAC));
    endfunction

    function automatic diir_pkg::hist_t iir_update(input bit lowpass, input diir_pkg::smp_t x,
                                                   inout iir_hist_t st);
        int                   order;
        logic signed [127:0]  acc;
        logic signed [127:0]  cb;
        logic signed [127:0]  ca;
        logic signed [127:0]  xv;
        logic signed [127:0]  yv;
        diir_pkg::hist_t      y;
        order = lowpass ? diir_pkg::LP_ORDER : diir_pkg::HP_ORDER;
        cb = lowpass ? lp_b_q[0] : hp_b_q[0];
        xv = x;
        acc = cb * (xv <<< diir_pkg::OUT_FRAC);
        for (int k = 1; k <= order; k++) begin
            cb = lowpass ? lp_b_q[k] : hp_b_q[k];
            ca = lowpass ? lp_na_q[k-1] : hp_na_q[k-1];
            xv = st.x[k-1];
            yv = st.y[k-1];
            acc = acc + cb * (xv <<< diir_pkg::OUT_FRAC) + ca * yv;
        end
        acc = acc >>> diir_pkg::COEF_FRAC_BITS;
        if (acc > HIST_HI) begin
            acc = HIST_HI;
        end else if (acc < HIST_LO) begin
            acc = HIST_LO;
        end
        y = acc[diir_pkg::HIST_W-1:0];
        for (int k = order - 1; k > 0; k--) begin
            st.x[k] = st.x[k-1];
            st.y[k] = st.y[k-1];
        end
        st.x[0] = x;
        st.y[0] = y;
        return y;
    endfunction

    function automatic chan_result_t filter_and_defect(input logic [diir_pkg::CH_W-1:0] ch,
                                                       input diir_pkg::smp_t x);
        iir_hist_t      st;
        diir_pkg::smp_t filt;
        diir_pkg::smp_t lp;
        longint         d;
        chan_result_t   r;
        st = hp_state[ch];
        filt = to_integer(iir_update(1'b0, x, st));
        hp_state[ch] = st;
        st = lp_state[ch];
        lp = to_integer(iir_update(1'b1, filt, st));
        lp_state[ch] = st;
        d = longint'(last_filtered[ch]) - longint'(lp);
        if (d > SMP_HI) begin
            d = SMP_HI;
        end else if (d < SMP_LO) begin
            d = SMP_LO;
        end
        last_filtered[ch] = filt;
        r.ch = ch;
        r.filt = filt;
        r.dfct = diir_pkg::smp_t'(d);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_sample(input logic [diir_pkg::CH_W-1:0] ch, input diir_pkg::smp_t smp,
                               input bit typed, input chan_result_t typed_res);
        chan_result_t res;
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_channel <= ch;
        s_sample  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (ch < diir_pkg::CHANNELS) begin
            res = filter_and_defect(ch, smp);
            results_due.push_back(typed ? typed_res : res);
        end
        @(negedge aclk);
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (stall_req && !stall_done) begin
                stall_done = 1'b1;
                m_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        chan_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result, channel", m_channel_out, -1);
            end else begin
                want = results_due.pop_front();
                if (m_channel_out !== want.ch) begin
                    report_mismatch("channel_out", m_channel_out, want.ch);
                end
                if (m_filtered !== want.filt) begin
                    report_mismatch("filtered", m_filtered, want.filt);
                end
                if (m_defect !== want.dfct) begin
                    report_mismatch("defect", m_defect, want.dfct);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        int                        n;
        int                        phase;
        logic [diir_pkg::CH_W-1:0] ch;
        diir_pkg::smp_t            smp;
        chan_result_t              typed_res;
        for (int k = 0; k <= diir_pkg::HP_ORDER; k++) begin
            hp_b_q[k] = quantise_coef(HP_B_DEC[k]);
        end
        for (int k = 0; k < diir_pkg::HP_ORDER; k++) begin
            hp_na_q[k] = -quantise_coef(HP_A_DEC[k]);
        end
        for (int k = 0; k <= diir_pkg::LP_ORDER; k++) begin
            lp_b_q[k] = quantise_coef(LP_B_DEC[k]);
        end
        for (int k = 0; k < diir_pkg::LP_ORDER; k++) begin
            lp_na_q[k] = -quantise_coef(LP_A_DEC[k]);
        end
        for (int c = 0; c < diir_pkg::CHANNELS; c++) begin
            for (int k = 0; k < diir_pkg::LP_ORDER; k++) begin
                hp_state[c].x[k] = '0;
                hp_state[c].y[k] = '0;
                lp_state[c].x[k] = '0;
                lp_state[c].y[k] = '0;
            end
            last_filtered[c] = '0;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            typed_res.ch   = DIRECTED_ROWS[i].ch;
            typed_res.filt = DIRECTED_ROWS[i].filt;
            typed_res.dfct = DIRECTED_ROWS[i].dfct;
            send_sample(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].typed,
                        typed_res);
        end

        n = 0;
        phase = 1;
        while (n < RANDOM_ITEMS) begin
            if (n >= 2 * RANDOM_ITEMS / 3 && phase != 3) begin
                phase = 3;
                send_idle = 0;
                recv_idle = 0;
                stall_req = 1'b1;
            end else if (n >= RANDOM_ITEMS / 3 && phase == 1) begin
                phase = 2;
                send_idle = 58;
                recv_idle = 24;
            end
            if ($urandom_range(0, 99) < 12) begin
                ch = diir_pkg::CH_W'($urandom_range(diir_pkg::CHANNELS, 15));
            end else begin
                ch = diir_pkg::CH_W'($urandom_range(0, diir_pkg::CHANNELS - 1));
            end
            case ($urandom_range(0, 9))
                0:       smp = diir_pkg::smp_t'(SMP_LO);
                1:       smp = diir_pkg::smp_t'(SMP_HI);
                2, 3:    smp = diir_pkg::smp_t'(int'($urandom_range(0, 64)) - 32);
                default: smp = diir_pkg::smp_t'($urandom);
            endcase
            send_sample(ch, smp, 1'b0, typed_res);
            n++;
        end
        s_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/diir_pkg.sv
hw/rtl/dual_iir_defect_channel_filter_unit.sv
tb/testbench.sv
